FILE: rtl/assert_macros.svh
// assertion macros shared by the min tracking stack modules
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define MTS_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/mts_pkg.sv
// types and codes for the min tracking stack
// no dependencies; used by mts_ctrl, mts_datapath and min_tracking_stack
package mts_pkg;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam int VALUE_W = 32;
    localparam int FILL_W  = 7;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic push;   // write new entry, bump count
        logic pop;    // drop count, start read of new top
        logic load;   // take read data into the top cache
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic deep;   // two or more entries held
    } flags_t;

endpackage

FILE: rtl/mts_ctrl.sv
// controller state machine for the min tracking stack
// depends on mts_pkg and assert_macros.svh
`include "assert_macros.svh"

module mts_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            kind,
    input  mts_pkg::flags_t flags,
    output mts_pkg::cmd_t   cmd,
    output logic            busy,
    output logic            done,
    output logic [1:0]      status
);

    typedef enum logic {
        S_IDLE,
        S_POP_LOAD
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             done_reg;
    logic             done_next;
    mts_pkg::status_t status_reg;
    mts_pkg::status_t status_next;
    logic             accept;

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = mts_pkg::ST_OK;
                    done_next   = 1'b1;
                    if (kind == mts_pkg::KIND_PUSH)
                    begin
                        if (flags.full)
                            status_next = mts_pkg::ST_OVERFLOW;
                        else
                            cmd.push = 1'b1;
                    end
                    else
                    begin
                        if (flags.empty)
                            status_next = mts_pkg::ST_UNDERFLOW;
                        else
                        begin
                            cmd.pop = 1'b1;
                            // new top lives in memory, wait for the read
                            if (flags.deep)
                            begin
                                done_next  = 1'b0;
                                state_next = S_POP_LOAD;
                            end
                        end
                    end
                end
            end
            S_POP_LOAD:
            begin
                cmd.load   = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            status_reg <= mts_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

    `MTS_ASSERT(a_quick_done, clk, rst_n,
        (accept && !(kind == mts_pkg::KIND_POP && !flags.empty && flags.deep)) |=> done,
        "push or shallow pop did not finish in one cycle")
    `MTS_NEVER(a_done_busy, clk, rst_n, done && busy, "result word shown while busy")
    `MTS_ASSERT(a_overflow, clk, rst_n,
        (accept && kind == mts_pkg::KIND_PUSH && flags.full)
            |=> (status == mts_pkg::ST_OVERFLOW),
        "push on full stack not flagged as overflow")

endmodule

FILE: rtl/mts_datapath.sv
// storage and minimum tracking datapath for the min tracking stack
// depends on mts_pkg and assert_macros.svh
`include "assert_macros.svh"

module mts_datapath
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [mts_pkg::VALUE_W-1:0]    value,
    input  mts_pkg::cmd_t                         cmd,
    output mts_pkg::flags_t                       flags,
    output logic signed [mts_pkg::VALUE_W-1:0]    top_value,
    output logic signed [mts_pkg::VALUE_W-1:0]    min_value,
    output logic [mts_pkg::FILL_W-1:0]            fill_count,
    output logic                                  is_empty
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ENT_W  = 2 * mts_pkg::VALUE_W;

    // each entry holds {value, minimum of it and everything below}
    logic [ENT_W-1:0] mem [STACK_DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]                      count_reg;
    logic [CNT_W-1:0]                      count_next;
    logic signed [mts_pkg::VALUE_W-1:0]    top_val_reg;
    logic signed [mts_pkg::VALUE_W-1:0]    top_val_next;
    logic signed [mts_pkg::VALUE_W-1:0]    top_min_reg;
    logic signed [mts_pkg::VALUE_W-1:0]    top_min_next;
    logic signed [mts_pkg::VALUE_W-1:0]    push_min;
    logic [CNT_W-1:0]                      rd_sum;
    logic [ADDR_W-1:0]                     wr_addr;
    logic [ADDR_W-1:0]                     rd_addr;
    logic [CNT_W:0]                        count_ext;
    logic [CNT_W+mts_pkg::FILL_W-1:0]      count_wide;

    assign count_ext = (CNT_W + 1)'(count_reg);
    assign flags.empty = (count_reg == '0);
    assign flags.full  = (count_ext == (CNT_W + 1)'(STACK_DEPTH));
    assign flags.deep  = (count_ext >= (CNT_W + 1)'(2));

    assign wr_addr = count_reg[ADDR_W-1:0];
    assign rd_sum  = count_reg - CNT_W'(2);
    assign rd_addr = rd_sum[ADDR_W-1:0];

    assign push_min = (flags.empty || (value < top_min_reg)) ? value : top_min_reg;

    always_comb
    begin
        count_next   = count_reg;
        top_val_next = top_val_reg;
        top_min_next = top_min_reg;
        if (cmd.push)
        begin
            count_next   = count_reg + CNT_W'(1);
            top_val_next = value;
            top_min_next = push_min;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.load)
        begin
            top_val_next = rd_data_reg[ENT_W-1:mts_pkg::VALUE_W];
            top_min_next = rd_data_reg[mts_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        top_val_reg <= top_val_next;
        top_min_reg <= top_min_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[wr_addr] <= {value, push_min};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
            rd_data_reg <= mem[rd_addr];
    end

    assign count_wide = (CNT_W + mts_pkg::FILL_W)'(count_reg);
    assign fill_count = count_wide[mts_pkg::FILL_W-1:0];
    assign is_empty   = flags.empty;
    assign top_value  = flags.empty ? '0 : top_val_reg;
    assign min_value  = flags.empty ? '0 : top_min_reg;

    `MTS_ASSERT(a_count_bound, clk, rst_n,
        count_ext <= (CNT_W + 1)'(STACK_DEPTH), "entry count above stack depth")
    `MTS_NEVER(a_push_full, clk, rst_n, cmd.push && flags.full, "write on a full stack")

endmodule

FILE: rtl/min_tracking_stack.sv
// top level of the min tracking stack: bounded stack with running minimum
// depends on mts_pkg, mts_ctrl and mts_datapath
//
//   port group   dir   handshake         payload
//   command      in    start / busy      kind, value
//   result       out   done (1 cycle)    top_value, min_value, fill_count, is_empty, status
//
// a push, a rejected op, or a pop leaving the stack empty keeps busy low,
//   and done pulses on the following cycle
// a pop leaving entries behind waits in the load state for the registered
//   read of the entry memory; busy is high for one cycle
// reset clears the entry count and the controller; the memory needs no clearing pass
// the receiver cannot stall; a new command is taken in the cycle done is high
module min_tracking_stack
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  kind,
    input  logic signed [mts_pkg::VALUE_W-1:0]    value,
    output logic                                  done,
    output logic signed [mts_pkg::VALUE_W-1:0]    top_value,
    output logic signed [mts_pkg::VALUE_W-1:0]    min_value,
    output logic [mts_pkg::FILL_W-1:0]            fill_count,
    output logic                                  is_empty,
    output logic [1:0]                            status
);

    mts_pkg::cmd_t   cmd;
    mts_pkg::flags_t flags;

    mts_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .flags  (flags),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .status (status)
    );

    mts_datapath
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .flags      (flags),
        .top_value  (top_value),
        .min_value  (min_value),
        .fill_count (fill_count),
        .is_empty   (is_empty)
    );

endmodule

FILE: tb/min_tracking_stack_test.sv
// self-checking testbench for min_tracking_stack: a directed push/pop table, then random runs
// predicts each untyped result word with its own stack model; depends on mts_pkg and the rtl top
module min_tracking_stack_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W        = mts_pkg::VALUE_W;
    localparam int FILL_W         = mts_pkg::FILL_W;
    localparam int DEPTH          = 64;
    localparam int RANDOM_ITEMS   = 500;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] top;
        logic signed [VALUE_W-1:0] low;
        logic [FILL_W-1:0]         fill;
        logic                      empty;
        mts_pkg::status_t          st;
    } stack_view_t;

    typedef struct {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        stack_view_t               want;
    } op_word_t;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic kind = mts_pkg::KIND_PUSH;
    logic signed [VALUE_W-1:0] value = '0;
    logic busy;
    logic done;
    logic signed [VALUE_W-1:0] top_value;
    logic signed [VALUE_W-1:0] min_value;
    logic [FILL_W-1:0] fill_count;
    logic is_empty;
    logic [1:0] status;

    // typed expectation travels with the word it belongs to
    bit typed_row = 1'b0;
    stack_view_t typed_view = '0;

    // predictor state
    logic signed [VALUE_W-1:0] held_values [DEPTH];
    logic signed [VALUE_W-1:0] held_minima [DEPTH];
    int held_count = 0;

    stack_view_t pending_views[$];
    int mismatches = 0;
    int results_seen = 0;
    int idle_cycles = 0;

    // sender side bookkeeping
    int drive_fill = 0;
    int words_sent = 0;
    int calm_from = 0;
    int calm_to = 0;

    min_tracking_stack #(
        .STACK_DEPTH(DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .value      (value),
        .done       (done),
        .top_value  (top_value),
        .min_value  (min_value),
        .fill_count (fill_count),
        .is_empty   (is_empty),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] result %0d: %s", $realtime, results_seen, what);
        mismatches++;
    endtask

    // applies one operation to the model stack and returns the view after it
    function automatic stack_view_t apply_op(input logic op, input logic signed [VALUE_W-1:0] v);
        stack_view_t r;
        logic signed [VALUE_W-1:0] m;
        r.st = mts_pkg::ST_OK;
        if (op == mts_pkg::KIND_PUSH)
        begin
            if (held_count == DEPTH)
            begin
                r.st = mts_pkg::ST_OVERFLOW;
            end
            else
            begin
                m = v;
                if (held_count > 0 && held_minima[held_count-1] < v)
                    m = held_minima[held_count-1];
                held_values[held_count] = v;
                held_minima[held_count] = m;
                held_count++;
            end
        end
        else if (held_count == 0)
        begin
            r.st = mts_pkg::ST_UNDERFLOW;
        end
        else
        begin
            held_count--;
        end
        r.top   = (held_count > 0) ? held_values[held_count-1] : '0;
        r.low   = (held_count > 0) ? held_minima[held_count-1] : '0;
        r.fill  = FILL_W'(held_count);
        r.empty = (held_count == 0);
        return r;
    endfunction

    // result words are checked before the new command enters the model
    always @(posedge clk)
    begin
        stack_view_t want;
        stack_view_t model;
        if (rst_n)
        begin
            if (done)
            begin
                results_seen++;
                if (pending_views.size() == 0)
                begin
                    flag_mismatch("result word with nothing outstanding");
                end
                else
                begin
                    want = pending_views.pop_front();
                    if (top_value !== want.top)
                        flag_mismatch($sformatf("top_value %0d, want %0d", top_value, want.top));
                    if (min_value !== want.low)
                        flag_mismatch($sformatf("min_value %0d, want %0d", min_value, want.low));
                    if (fill_count !== want.fill)
                        flag_mismatch($sformatf("fill_count %0d, want %0d", fill_count,
                                                want.fill));
                    if (is_empty !== want.empty)
                        flag_mismatch($sformatf("is_empty %b, want %b", is_empty, want.empty));
                    if (status !== want.st)
                        flag_mismatch($sformatf("status %0d, want %s", status, want.st.name()));
                end
            end
            if (start && !busy)
            begin
                model = apply_op(kind, value);
                pending_views.push_back(typed_row ? typed_view : model);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("min_tracking_stack regression: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic op_word_t row(input logic op, input logic signed [VALUE_W-1:0] v,
                                     input bit typed = 1'b0,
                                     input logic signed [VALUE_W-1:0] top = '0,
                                     input logic signed [VALUE_W-1:0] low = '0,
                                     input int fill = 0, input logic empty = 1'b0,
                                     input mts_pkg::status_t st = mts_pkg::ST_OK);
        op_word_t w;
        w.kind       = op;
        w.value      = v;
        w.typed      = typed;
        w.want.top   = top;
        w.want.low   = low;
        w.want.fill  = FILL_W'(fill);
        w.want.empty = empty;
        w.want.st    = st;
        return w;
    endfunction

    // mix of extremes, small values that tie often, and full-range values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2, 3, 4: return $signed(VALUE_W'($urandom_range(16))) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic op_word_t make_word(input logic op);
        return row(op, pick_value());
    endfunction

    // outside the calm window, each cycle idles with a chance of 21 in a hundred
    function automatic int pick_gap();
        int gap;
        gap = 0;
        if (words_sent >= calm_from && words_sent < calm_to)
            return 0;
        while ($urandom_range(99) < 21)
            gap++;
        return gap;
    endfunction

    // drives one word and returns once it is taken and busy has dropped
    task automatic send_word(input op_word_t w, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        kind       <= w.kind;
        value      <= w.value;
        typed_row  <= w.typed;
        typed_view <= w.want;
        @(posedge clk);
        while (busy) @(posedge clk);
        words_sent++;
        if (w.kind == mts_pkg::KIND_PUSH && drive_fill < DEPTH)
            drive_fill++;
        else if (w.kind == mts_pkg::KIND_POP && drive_fill > 0)
            drive_fill--;
    endtask

    // hold off the sender until every outstanding word has come back
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_views.size() != 0) @(posedge clk);
    endtask

    // fill past full, then drain past empty
    task automatic sweep();
        while (drive_fill < DEPTH) send_word(make_word(mts_pkg::KIND_PUSH), pick_gap());
        repeat (1 + $urandom_range(2)) send_word(make_word(mts_pkg::KIND_PUSH), pick_gap());
        while (drive_fill > 0) send_word(make_word(mts_pkg::KIND_POP), pick_gap());
        repeat (1 + $urandom_range(1)) send_word(make_word(mts_pkg::KIND_POP), pick_gap());
    endtask

    initial
    begin
        op_word_t directed[$];
        int target;
        int push_pct;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        directed.push_back(row(mts_pkg::KIND_POP,  32'sd5, 1, 0, 0, 0, 1,
                               mts_pkg::ST_UNDERFLOW));
        directed.push_back(row(mts_pkg::KIND_PUSH, 32'sd0, 1, 0, 0, 1, 0, mts_pkg::ST_OK));
        directed.push_back(row(mts_pkg::KIND_PUSH, VAL_MAX, 1, VAL_MAX, 0, 2, 0,
                               mts_pkg::ST_OK));
        directed.push_back(row(mts_pkg::KIND_PUSH, VAL_MIN, 1, VAL_MIN, VAL_MIN, 3, 0,
                               mts_pkg::ST_OK));
        directed.push_back(row(mts_pkg::KIND_PUSH, -32'sd1, 1, -1, VAL_MIN, 4, 0,
                               mts_pkg::ST_OK));
        directed.push_back(row(mts_pkg::KIND_POP,  -32'sd1, 1, VAL_MIN, VAL_MIN, 3, 0,
                               mts_pkg::ST_OK));
        directed.push_back(row(mts_pkg::KIND_POP,  VAL_MAX, 1, VAL_MAX, 0, 2, 0,
                               mts_pkg::ST_OK));
        directed.push_back(row(mts_pkg::KIND_POP,  VAL_MIN, 1, 0, 0, 1, 0, mts_pkg::ST_OK));
        // pop that leaves the stack empty
        directed.push_back(row(mts_pkg::KIND_POP,  32'sd0, 1, 0, 0, 0, 1, mts_pkg::ST_OK));
        directed.push_back(row(mts_pkg::KIND_POP,  -32'sd1, 1, 0, 0, 0, 1,
                               mts_pkg::ST_UNDERFLOW));
        directed.push_back(row(mts_pkg::KIND_PUSH, -32'sd1, 1, -1, -1, 1, 0, mts_pkg::ST_OK));
        // equal values keep the older minimum
        directed.push_back(row(mts_pkg::KIND_PUSH, 32'sd5));
        directed.push_back(row(mts_pkg::KIND_PUSH, 32'sd5));
        directed.push_back(row(mts_pkg::KIND_PUSH, -32'sd1));
        directed.push_back(row(mts_pkg::KIND_PUSH, 32'sd3));
        directed.push_back(row(mts_pkg::KIND_POP,  32'sd0));
        directed.push_back(row(mts_pkg::KIND_POP,  32'sd0));
        directed.push_back(row(mts_pkg::KIND_POP,  32'sd0));
        directed.push_back(row(mts_pkg::KIND_POP,  32'sd0));
        directed.push_back(row(mts_pkg::KIND_POP,  32'sd0));
        directed.push_back(row(mts_pkg::KIND_PUSH, VAL_MAX));
        directed.push_back(row(mts_pkg::KIND_PUSH, VAL_MAX));
        directed.push_back(row(mts_pkg::KIND_POP,  VAL_MIN));
        directed.push_back(row(mts_pkg::KIND_POP,  VAL_MIN));

        foreach (directed[i])
            send_word(directed[i], pick_gap());
        settle();

        target    = words_sent + RANDOM_ITEMS;
        calm_from = words_sent + 150;
        calm_to   = words_sent + 300;
        sweep();
        while (words_sent < target)
        begin
            if ($urandom_range(9) < 2)
            begin
                sweep();
            end
            else
            begin
                case ($urandom_range(2))
                    0: push_pct = 35;
                    1: push_pct = 50;
                    default: push_pct = 70;
                endcase
                repeat ($urandom_range(20, 40))
                    send_word(make_word(($urandom_range(99) < push_pct) ?
                                        mts_pkg::KIND_PUSH : mts_pkg::KIND_POP),
                              pick_gap());
            end
            if ($urandom_range(4) == 0)
                settle();
        end

        settle();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("min_tracking_stack regression: pass");
        else
            $display("min_tracking_stack regression: fail");
        $finish;
    end

endmodule
